// ===== design/ktsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ktsr_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int MODE_W    = 3;
    localparam int KEY_W     = 32;
    localparam int TMPL_W    = 32;
    localparam int POS_W     = 6;
    localparam int AMT_W     = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEL    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROOM   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  entry_key;
        logic [TMPL_W-1:0] template_id;
        logic [POS_W-1:0]  position;
        logic [AMT_W-1:0]  amount;
    } t_request;

    typedef struct packed {
        logic                 ok;
        logic [POS_W-1:0]     found_position;
        logic [KEY_W-1:0]     found_key;
        logic [TMPL_W-1:0]    found_template;
        logic [CNT_OUT_W-1:0] fill_count;
        logic                 is_full;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_READ,
        ST_MOVE
    } t_state;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_POS,
        RD_LAST
    } t_rd_sel;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_REQ,
        POS_CMP,
        POS_AT
    } t_pos_sel;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     scan_step;
        logic     wr_add;
        logic     wr_move;
        logic     cnt_dec;
        logic     at_load;
        logic     emit;
        logic     res_ok;
        t_pos_sel res_pos;
        logic     res_data;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              has_room;
        logic              count_zero;
        logic              pos_valid;
        logic              room_ok;
        logic              idx_in_range;
        logic              cmp_valid;
        logic              match;
        logic              cmp_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/ktsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktsr_ctrl import ktsr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                case (i_status.mode)
                    MODE_ADD: begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.res_ok = i_status.has_room;
                        o_cmd.wr_add = i_status.has_room;
                    end
                    MODE_ROOM: begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.res_ok = i_status.room_ok;
                    end
                    MODE_READ: begin
                        if (i_status.pos_valid) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_POS;
                            n_state      = ST_READ;
                        end else begin
                            o_cmd.emit = 1'b1;
                        end
                    end
                    MODE_LOOKUP, MODE_DEL: begin
                        if (i_status.count_zero) begin
                            o_cmd.emit = 1'b1;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                if (i_status.match) begin
                    if (i_status.mode == MODE_LOOKUP) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_ok   = 1'b1;
                        o_cmd.res_pos  = POS_CMP;
                        o_cmd.res_data = 1'b1;
                        n_state        = ST_IDLE;
                    end else if (i_status.cmp_last) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.res_ok  = 1'b1;
                        o_cmd.res_pos = POS_CMP;
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        // fetch the last entry to fill the hole
                        o_cmd.at_load = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = RD_LAST;
                        n_state       = ST_MOVE;
                    end
                end else if (i_status.cmp_valid && i_status.cmp_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.rd_en     = i_status.idx_in_range;
                    o_cmd.rd_sel    = RD_IDX;
                end
            end
            ST_READ: begin
                o_cmd.emit     = 1'b1;
                o_cmd.res_ok   = 1'b1;
                o_cmd.res_pos  = POS_REQ;
                o_cmd.res_data = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_MOVE: begin
                o_cmd.wr_move = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                o_cmd.emit    = 1'b1;
                o_cmd.res_ok  = 1'b1;
                o_cmd.res_pos = POS_AT;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/ktsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktsr_datapath import ktsr_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_request   i_request,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output logic            o_done,
    output t_result         o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 1;

    logic [KEY_W-1:0]  r_key_mem  [CAPACITY];
    logic [TMPL_W-1:0] r_tmpl_mem [CAPACITY];

    t_request          r_req;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_valid;
    logic [IDX_W-1:0]  r_at;
    logic [KEY_W-1:0]  r_rd_key;
    logic [TMPL_W-1:0] r_rd_tmpl;

    logic              r_res_valid;
    logic              r_res_ok;
    logic [IDX_W-1:0]  r_res_pos;
    logic [KEY_W-1:0]  r_res_key;
    logic [TMPL_W-1:0] r_res_tmpl;

    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [TMPL_W-1:0] wr_tmpl;
    logic              wr_en;
    logic [IDX_W-1:0]  n_res_pos;

    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:  rd_addr = r_idx[IDX_W-1:0];
            RD_POS:  rd_addr = IDX_W'(r_req.position);
            RD_LAST: rd_addr = last_idx;
            default: rd_addr = '0;
        endcase
    end

    assign wr_en   = i_cmd.wr_add | i_cmd.wr_move;
    assign wr_addr = i_cmd.wr_move ? r_at : r_count[IDX_W-1:0];
    assign wr_key  = i_cmd.wr_move ? r_rd_key : r_req.entry_key;
    assign wr_tmpl = i_cmd.wr_move ? r_rd_tmpl : r_req.template_id;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr]  <= wr_key;
            r_tmpl_mem[wr_addr] <= wr_tmpl;
        end
        if (i_cmd.rd_en) begin
            r_rd_key  <= r_key_mem[rd_addr];
            r_rd_tmpl <= r_tmpl_mem[rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.res_pos)
            POS_ZERO: n_res_pos = '0;
            POS_REQ:  n_res_pos = IDX_W'(r_req.position);
            POS_CMP:  n_res_pos = r_cmp_idx;
            POS_AT:   n_res_pos = r_at;
            default:  n_res_pos = '0;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_request;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.at_load) begin
            r_at <= r_cmp_idx;
        end
        if (i_cmd.emit) begin
            r_res_ok   <= i_cmd.res_ok;
            r_res_pos  <= n_res_pos;
            r_res_key  <= i_cmd.res_data ? r_rd_key : '0;
            r_res_tmpl <= i_cmd.res_data ? r_rd_tmpl : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit;
            if (i_cmd.wr_add) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_cmp_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_idx < r_count) begin
                    r_idx       <= r_idx + CNT_W'(1);
                    r_cmp_valid <= 1'b1;
                end else begin
                    r_cmp_valid <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_status.mode         = r_req.mode;
        o_status.has_room     = (r_count < CNT_W'(CAPACITY));
        o_status.count_zero   = (r_count == '0);
        o_status.pos_valid    = (SUM_W'(r_req.position) < SUM_W'(r_count));
        o_status.room_ok      = ((SUM_W'(r_count) + SUM_W'(r_req.amount))
                                 <= SUM_W'(CAPACITY));
        o_status.idx_in_range = (r_idx < r_count);
        o_status.cmp_valid    = r_cmp_valid;
        o_status.match        = r_cmp_valid && (r_rd_key == r_req.entry_key);
        o_status.cmp_last     = (r_cmp_idx == last_idx);
    end

    assign o_done = r_res_valid;

    always_comb begin
        o_result.ok             = r_res_ok;
        o_result.found_position = POS_W'(r_res_pos);
        o_result.found_key      = r_res_key;
        o_result.found_template = r_res_tmpl;
        o_result.fill_count     = CNT_OUT_W'(r_count);
        o_result.is_full        = (r_count == CNT_W'(CAPACITY));
    end

endmodule

`default_nettype wire

// ===== design/keyed_table_swap_remove_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unordered table of (key, template id) entries with a fill count.
// A request on i_request is taken at a rising edge where start is high and
// busy is low; busy stays high until the result is out. Modes: add at the
// end, delete by key (last entry moves into the freed slot), lookup by key,
// read by position, capacity query. Key searches take the lowest match.
// Each request yields exactly one result on o_result, valid for the single
// cycle in which o_done is high; the receiver cannot stall it, and a new
// request may be taken in that same cycle.
// Add, capacity query and unused modes answer from the execute state; read
// by position goes on through a read state. Key searches walk the table
// through the single memory read port one entry a cycle: a lookup hit
// stops at the matching position, a miss walks all fill_count entries, and
// a delete passes through a move state when the last entry has to be moved.
// Back-to-back requests do not overlap, as the next one is taken
// at the edge that ends the o_done cycle.
// Reset (synchronous, active low) empties the table at once by clearing
// the fill count; entry storage is not cleared and needs no sweep.

module keyed_table_swap_remove_unit import ktsr_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_request,
    output logic          o_done,
    output t_result       o_result
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       accept;

    assign accept = start && !busy;

    ktsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ktsr_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but not busy next cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.fill_count <= CNT_OUT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_single_count_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_add && cmd.cnt_dec))
        else $error("count raised and lowered in one cycle");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ktsr_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int RANDOM_REQS = 950;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 80;
    localparam int POOL_SIZE   = 14;

    class swap_table_board;
        logic [KEY_W-1:0]  keys [CAP];
        logic [TMPL_W-1:0] tmpls [CAP];
        int                fill;
        t_result           expected_results[$];
        int                failures;
        int                mode_count[8];
        int                hits;
        int                checked;
        int                peak_fill;
        int                full_reached;

        function new();
            fill = 0;
            failures = 0;
            hits = 0;
            checked = 0;
            peak_fill = 0;
            full_reached = 0;
            foreach (mode_count[m]) mode_count[m] = 0;
        endfunction

        function bit find_key(logic [KEY_W-1:0] k, output int at);
            at = 0;
            for (int i = 0; i < fill; i++) begin
                if (keys[i] == k) begin
                    at = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(t_request r);
            t_result res;
            int      at;
            int      last;
            res = '0;
            mode_count[r.mode]++;
            case (r.mode)
                MODE_ADD: begin
                    if (fill < CAP) begin
                        keys[fill] = r.entry_key;
                        tmpls[fill] = r.template_id;
                        fill++;
                        res.ok = 1'b1;
                    end
                end
                MODE_DEL: begin
                    if (find_key(r.entry_key, at)) begin
                        last = fill - 1;
                        if (at != last) begin
                            keys[at] = keys[last];
                            tmpls[at] = tmpls[last];
                        end
                        fill = last;
                        res.ok = 1'b1;
                        res.found_position = at[POS_W-1:0];
                    end
                end
                MODE_LOOKUP: begin
                    if (find_key(r.entry_key, at)) begin
                        res.ok = 1'b1;
                        res.found_position = at[POS_W-1:0];
                        res.found_key = keys[at];
                        res.found_template = tmpls[at];
                    end
                end
                MODE_READ: begin
                    if (int'(r.position) < fill) begin
                        res.ok = 1'b1;
                        res.found_position = r.position;
                        res.found_key = keys[r.position];
                        res.found_template = tmpls[r.position];
                    end
                end
                MODE_ROOM: begin
                    res.ok = (fill + int'(r.amount) <= CAP);
                end
                default: begin
                end
            endcase
            res.fill_count = fill[CNT_OUT_W-1:0];
            res.is_full = (fill == CAP);
            if (res.ok) hits++;
            if (fill > peak_fill) peak_fill = fill;
            if (fill == CAP) full_reached++;
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, longint unsigned exp, longint unsigned act);
            if (exp != act) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result with nothing pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            exp = expected_results.pop_front();
            checked++;
            compare_field("ok", exp.ok, got.ok);
            compare_field("found_position", exp.found_position, got.found_position);
            compare_field("found_key", exp.found_key, got.found_key);
            compare_field("found_template", exp.found_template, got.found_template);
            compare_field("fill_count", exp.fill_count, got.fill_count);
            compare_field("is_full", exp.is_full, got.is_full);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_done;
    t_result  o_result;

    swap_table_board   board;
    int                cycle_count = 0;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    bit                quiet;

    keyed_table_swap_remove_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_request(i_request),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_done) board.check_result(o_result);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** keyed_table_swap_remove_unit: FAILED **");
            $finish;
        end
    end

    function automatic t_request make_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] k,
                                              logic [TMPL_W-1:0] t, int pos, int amt);
        t_request r;
        r.mode = mode;
        r.entry_key = k;
        r.template_id = t;
        r.position = pos[POS_W-1:0];
        r.amount = amt[AMT_W-1:0];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] search_key_pick();
        int pick;
        pick = $urandom_range(0, 99);
        if (board.fill > 0 && pick < 70) return board.keys[$urandom_range(0, board.fill - 1)];
        if (pick < 90) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic t_request random_request(bit grow);
        t_request r;
        int       pick;
        r.entry_key = $urandom;
        r.template_id = $urandom;
        r.position = POS_W'($urandom_range(0, 63));
        r.amount = AMT_W'($urandom_range(0, 64));
        pick = $urandom_range(0, 99);
        if (!grow && pick < 50) pick = pick + 12;
        if (pick < 55) begin
            r.mode = MODE_ADD;
            if ($urandom_range(0, 99) < 80) r.entry_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 67) begin
            r.mode = MODE_DEL;
            r.entry_key = search_key_pick();
        end else if (pick < 80) begin
            r.mode = MODE_LOOKUP;
            r.entry_key = search_key_pick();
        end else if (pick < 90) begin
            r.mode = MODE_READ;
            if (board.fill > 0 && $urandom_range(0, 99) < 75)
                r.position = POS_W'($urandom_range(0, board.fill - 1));
        end else if (pick < 98) begin
            r.mode = MODE_ROOM;
        end else begin
            r.mode = MODE_W'($urandom_range(5, 7));
        end
        return r;
    endfunction

    task automatic send_request(input t_request req);
        if (!quiet && $urandom_range(0, 99) < 32) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        start = 1'b1;
        i_request = req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_request(req);
        @(negedge i_clk);
    endtask

    initial begin
        t_request directed[$];
        bit       grow;
        int       settle;

        start = 1'b0;
        i_request = '0;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        board = new();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed.push_back(make_request(MODE_READ, '0, '0, 0, 0));
        directed.push_back(make_request(MODE_LOOKUP, '0, '0, 0, 0));
        directed.push_back(make_request(MODE_DEL, '0, '0, 0, 0));
        directed.push_back(make_request(MODE_ROOM, '0, '0, 0, 64));
        directed.push_back(make_request(MODE_ROOM, '1, '1, 63, 0));
        directed.push_back(make_request(MODE_ADD, '0, '0, 0, 0));
        directed.push_back(make_request(MODE_ADD, '1, '1, 63, 64));
        directed.push_back(make_request(MODE_ADD, '1, 32'h1234_5678, 0, 0));
        directed.push_back(make_request(MODE_LOOKUP, '1, '0, 0, 0));
        directed.push_back(make_request(MODE_READ, '0, '0, 2, 0));
        directed.push_back(make_request(MODE_READ, '0, '0, 3, 0));
        directed.push_back(make_request(MODE_READ, '0, '0, 63, 0));
        directed.push_back(make_request(MODE_ROOM, '0, '0, 0, 61));
        directed.push_back(make_request(MODE_ROOM, '0, '0, 0, 62));
        directed.push_back(make_request(MODE_DEL, '0, '0, 0, 0));
        directed.push_back(make_request(MODE_LOOKUP, '1, '0, 0, 0));
        directed.push_back(make_request(MODE_DEL, '1, '0, 0, 0));
        directed.push_back(make_request(MODE_DEL, '1, '0, 0, 0));
        directed.push_back(make_request(MODE_DEL, '1, '0, 0, 0));
        directed.push_back(make_request(MODE_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0));
        directed.push_back(make_request(MODE_ADD, 32'h1234_5678, '0, 0, 0));
        directed.push_back(make_request(MODE_DEL, 32'h1234_5678, '0, 0, 0));
        directed.push_back(make_request(3'd5, '1, '1, 63, 64));
        directed.push_back(make_request(3'd6, 32'hA5A5_A5A5, '0, 21, 33));
        directed.push_back(make_request(3'd7, '0, '0, 0, 0));
        foreach (directed[i]) send_request(directed[i]);

        grow = 1'b1;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            quiet = (i >= 250 && i < 450);
            if (i == 600) begin
                start = 1'b0;
                while (board.pending() != 0) @(negedge i_clk);
            end
            if (board.fill == CAP && $urandom_range(0, 99) < 25) grow = 1'b0;
            if (board.fill == 0 && $urandom_range(0, 99) < 50) grow = 1'b1;
            send_request(random_request(grow));
        end
        start = 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < SETTLE) begin
            @(posedge i_clk);
            settle++;
        end
        if (board.pending() != 0) begin
            board.failures++;
            $display("%0t: %0d results never arrived", $time, board.pending());
        end

        $display("checked %0d results: %0d add, %0d delete, %0d lookup, %0d read, %0d room",
                 board.checked, board.mode_count[MODE_ADD], board.mode_count[MODE_DEL],
                 board.mode_count[MODE_LOOKUP], board.mode_count[MODE_READ],
                 board.mode_count[MODE_ROOM]);
        $display("%0d successful, %0d unused modes, peak fill %0d, table full %0d times",
                 board.hits, board.mode_count[5] + board.mode_count[6] + board.mode_count[7],
                 board.peak_fill, board.full_reached);
        if (board.failures == 0) begin
            $display("** keyed_table_swap_remove_unit: PASSED **");
        end else begin
            $display("** keyed_table_swap_remove_unit: FAILED **");
        end
        $finish;
    end

endmodule
